// ----- hw/rtl/ogi_pkg.sv -----
// ----------------------------------------------------------------------------
// ogi_pkg
// shared types and constants for the occupancy grid inflation block
// ----------------------------------------------------------------------------
package ogi_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_RADIUS = 15;
  localparam int RING_DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int WIDTH_W    = $clog2(MAX_WIDTH + 1);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int RAD_W      = 4;
  localparam int PEND_W     = 15;
  localparam int ROW_W      = 16;
  localparam int OFS_W      = 17;

  localparam logic [1:0] CFG_MAP_WIDTH = 2'd0;
  localparam logic [1:0] CFG_RADIUS    = 2'd1;
  localparam logic [1:0] CFG_DISC      = 2'd2;

  localparam logic [7:0] FREE_MAX = 8'd50;
  localparam logic [7:0] WALL_MAX = 8'd100;
  localparam logic signed [7:0] OUT_WALL    = 8'sd100;
  localparam logic signed [7:0] OUT_FREE    = 8'sd0;
  localparam logic signed [7:0] OUT_UNKNOWN = -8'sd1;

  typedef enum logic [1:0] {
    CLS_FREE    = 2'd0,
    CLS_WALL    = 2'd1,
    CLS_UNKNOWN = 2'd2
  } cls_e;

  typedef enum logic {
    FUNC_CELL  = 1'b0,
    FUNC_DRAIN = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SELF,
    ST_SELFW,
    ST_ROW,
    ST_PIX,
    ST_PIXW,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              func;
    logic signed [7:0] cell_value;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] cell_out;
    logic              last;
  } out_item_t;

  typedef struct packed {
    func_e func;
    cls_e  cls;
  } job_t;

endpackage

// ----- hw/rtl/occupancy_grid_inflation_top.sv -----
// ----------------------------------------------------------------------------
// occupancy_grid_inflation_top
// a request that gives no result retires in the idle state as it leaves the queue
// a result reads its own cell and then the disc cells row by row, one ring read
// at a time; the scan stops at the first wall
// reset clears counters and config to defaults; ring contents stay undefined
// ----------------------------------------------------------------------------
module occupancy_grid_inflation_top import ogi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic push, pop, q_full, q_empty;
  job_t push_job, pop_job;

  assign cfg_ready_o = 1'b1;

  ogi_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  ogi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_job),
    .pop_i   (pop),
    .rdata_o (pop_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ogi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .job_i       (pop_job),
    .pop_o       (pop),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hw/rtl/ogi_front.sv -----
// ----------------------------------------------------------------------------
// ogi_front
// accepts requests and classifies the raw occupancy byte
// ----------------------------------------------------------------------------
module ogi_front import ogi_pkg::*; (
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  input  logic     q_full_i,
  output logic     push_o,
  output job_t     job_o
);

  logic [7:0] raw;

  assign raw        = in_data_i.cell_value;
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  always_comb begin
    job_o.func = in_data_i.func ? FUNC_DRAIN : FUNC_CELL;
    if (raw <= FREE_MAX) begin
      job_o.cls = CLS_FREE;
    end else if (raw <= WALL_MAX) begin
      job_o.cls = CLS_WALL;
    end else begin
      job_o.cls = CLS_UNKNOWN;
    end
  end

endmodule

// ----- hw/rtl/ogi_queue.sv -----
// ----------------------------------------------------------------------------
// ogi_queue
// two-entry queue between classifier and dilation engine
// ----------------------------------------------------------------------------
module ogi_queue import ogi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t wdata_i,
  input  logic pop_i,
  output job_t rdata_o,
  output logic full_o,
  output logic empty_o
);

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ----- hw/rtl/ogi_back.sv -----
// ----------------------------------------------------------------------------
// ogi_back
// class ring, disc scan sequencer, configuration and result register
// ----------------------------------------------------------------------------
module ogi_back import ogi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  job_t        job_i,
  output logic        pop_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o
);

  logic [1:0] ring [RING_DEPTH];
  logic [1:0] rd_data_q;
  logic [RING_AW-1:0] rd_addr;
  logic ring_we;

  state_e state_q, state_d;
  logic [WIDTH_W-1:0] width_q, width_d;
  logic [RAD_W-1:0]   radius_q, radius_d;
  logic [63:0]        disc_q, disc_d;
  logic [PEND_W-1:0]  lag_q, lag_d;
  logic [RING_AW-1:0] wp_q, wp_d, base_q, base_d;
  logic [PEND_W-1:0]  pend_q, pend_d;
  logic               drain_q, drain_d;
  logic [COL_W-1:0]   ocol_q, ocol_d;
  logic [ROW_W-1:0]   orow_q, orow_d;
  logic               isdrain_q, isdrain_d;
  logic [1:0]         self_q, self_d;
  logic signed [4:0]  dy_q, dy_d, dx_q, dx_d;
  logic [RAD_W-1:0]   hw_q, hw_d;
  logic signed [OFS_W-1:0] rowd_q, rowd_d;
  logic               hit_q, hit_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic [WIDTH_W-1:0] cfg_w;
  logic [RAD_W-1:0]   k, fld, hw_c;
  logic signed [OFS_W-1:0] d_c;
  logic signed [COL_W+1:0] c_c;
  logic signed [RING_AW+2:0] sum_c;
  logic [RING_AW:0]   bt_c;
  logic [PEND_W-1:0]  pnew;
  logic               pix_ok, last_row;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring[wp_q] <= job_i.cls;
    end
    rd_data_q <= ring[rd_addr];
  end

  always_comb begin
    k      = dy_q[4] ? RAD_W'(-dy_q) : dy_q[RAD_W-1:0];
    fld    = disc_q[{k, 2'b00} +: 4];
    hw_c   = (fld > radius_q) ? radius_q : fld;
    d_c    = rowd_q + OFS_W'(dx_q);
    c_c    = $signed({2'b00, ocol_q}) + (COL_W+2)'(dx_q);
    pix_ok = (c_c >= 0) && (c_c < $signed({1'b0, width_q})) &&
             (d_c < $signed({2'b00, pend_q}));
    sum_c  = $signed({3'b000, base_q}) + (RING_AW+3)'(d_c);
    if (sum_c < 0) begin
      sum_c = sum_c + (RING_AW+3)'(RING_DEPTH);
    end else if (sum_c >= (RING_AW+3)'(RING_DEPTH)) begin
      sum_c = sum_c - (RING_AW+3)'(RING_DEPTH);
    end
    bt_c = {1'b0, wp_q} + (RING_AW+1)'(RING_DEPTH) - (RING_AW+1)'(pend_q);
    if (bt_c >= (RING_AW+1)'(RING_DEPTH)) begin
      bt_c = bt_c - (RING_AW+1)'(RING_DEPTH);
    end
    last_row = (dy_q == $signed({1'b0, radius_q}));
    cfg_w = cfg_data_i[WIDTH_W-1:0];
    if (cfg_w == '0) begin
      cfg_w = WIDTH_W'(1);
    end else if (cfg_w > WIDTH_W'(MAX_WIDTH)) begin
      cfg_w = WIDTH_W'(MAX_WIDTH);
    end
  end

  always_comb begin
    state_d     = state_q;
    width_d     = width_q;
    radius_d    = radius_q;
    disc_d      = disc_q;
    lag_d       = lag_q;
    wp_d        = wp_q;
    base_d      = base_q;
    pend_d      = pend_q;
    drain_d     = drain_q;
    ocol_d      = ocol_q;
    orow_d      = orow_q;
    isdrain_d   = isdrain_q;
    self_d      = self_q;
    dy_d        = dy_q;
    dx_d        = dx_q;
    hw_d        = hw_q;
    rowd_d      = rowd_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    pop_o       = 1'b0;
    ring_we     = 1'b0;
    rd_addr     = base_q;
    pnew        = pend_q + PEND_W'(1);

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAP_WIDTH: begin
          width_d = cfg_w;
          lag_d   = PEND_W'(radius_q * cfg_w) + PEND_W'(radius_q);
          pend_d = '0; drain_d = 1'b0; ocol_d = '0; orow_d = '0;
        end
        CFG_RADIUS: begin
          radius_d = cfg_data_i[RAD_W-1:0];
          lag_d    = PEND_W'(cfg_data_i[RAD_W-1:0] * width_q) +
                     PEND_W'(cfg_data_i[RAD_W-1:0]);
          pend_d = '0; drain_d = 1'b0; ocol_d = '0; orow_d = '0;
        end
        CFG_DISC: disc_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i && !out_valid_q) begin
          pop_o     = 1'b1;
          isdrain_d = (job_i.func == FUNC_DRAIN);
          if (job_i.func == FUNC_CELL) begin
            ring_we = 1'b1;
            wp_d    = (wp_q == RING_AW'(RING_DEPTH - 1)) ? '0 : wp_q + RING_AW'(1);
            if (drain_q) begin
              pnew    = PEND_W'(1);
              drain_d = 1'b0;
              ocol_d  = '0;
              orow_d  = '0;
            end
            pend_d = pnew;
            if (pnew > lag_q) begin
              state_d = ST_SELF;
            end
          end else if (pend_q == '0) begin
            drain_d = 1'b0;
            ocol_d  = '0;
            orow_d  = '0;
          end else begin
            state_d = ST_SELF;
          end
        end
      end
      ST_SELF: begin
        rd_addr = bt_c[RING_AW-1:0];
        base_d  = bt_c[RING_AW-1:0];
        state_d = ST_SELFW;
      end
      ST_SELFW: begin
        self_d  = rd_data_q;
        hit_d   = 1'b0;
        dy_d    = -$signed({1'b0, radius_q});
        rowd_d  = -$signed({2'b00, lag_q - PEND_W'(radius_q)});
        state_d = ST_ROW;
      end
      ST_ROW: begin
        if (dy_q[4] && (orow_q < ROW_W'(k))) begin
          if (last_row) begin
            state_d = ST_DONE;
          end else begin
            dy_d   = dy_q + 5'sd1;
            rowd_d = rowd_q + $signed({6'd0, width_q});
          end
        end else begin
          hw_d    = hw_c;
          dx_d    = -$signed({1'b0, hw_c});
          state_d = ST_PIX;
        end
      end
      ST_PIX, ST_PIXW: begin
        rd_addr = sum_c[RING_AW-1:0];
        if (state_q == ST_PIX && pix_ok) begin
          state_d = ST_PIXW;
        end else if (state_q == ST_PIXW && rd_data_q == CLS_WALL) begin
          hit_d   = 1'b1;
          state_d = ST_DONE;
        end else if (dx_q == $signed({1'b0, hw_q})) begin
          if (last_row) begin
            state_d = ST_DONE;
          end else begin
            dy_d    = dy_q + 5'sd1;
            rowd_d  = rowd_q + $signed({6'd0, width_q});
            state_d = ST_ROW;
          end
        end else begin
          dx_d    = dx_q + 5'sd1;
          state_d = ST_PIX;
        end
      end
      ST_DONE: begin
        out_valid_d = 1'b1;
        if (hit_q || self_q == CLS_WALL) begin
          out_d.cell_out = OUT_WALL;
        end else if (self_q == CLS_FREE) begin
          out_d.cell_out = OUT_FREE;
        end else begin
          out_d.cell_out = OUT_UNKNOWN;
        end
        out_d.last = 1'b0;
        pend_d     = pend_q - PEND_W'(1);
        if ({1'b0, ocol_q} + WIDTH_W'(1) == width_q) begin
          ocol_d = '0;
          if (orow_q != '1) begin
            orow_d = orow_q + ROW_W'(1);
          end
        end else begin
          ocol_d = ocol_q + COL_W'(1);
        end
        if (isdrain_q) begin
          if (pend_q == PEND_W'(1)) begin
            out_d.last = 1'b1;
            drain_d    = 1'b0;
            ocol_d     = '0;
            orow_d     = '0;
          end else begin
            drain_d = 1'b1;
          end
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    base_q    <= base_d;
    isdrain_q <= isdrain_d;
    self_q    <= self_d;
    dy_q      <= dy_d;
    dx_q      <= dx_d;
    hw_q      <= hw_d;
    rowd_q    <= rowd_d;
    hit_q     <= hit_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= WIDTH_W'(MAX_WIDTH);
      radius_q    <= RAD_W'(5);
      disc_q      <= 64'd214357;
      lag_q       <= PEND_W'(5 * MAX_WIDTH + 5);
      wp_q        <= '0;
      pend_q      <= '0;
      drain_q     <= 1'b0;
      ocol_q      <= '0;
      orow_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      width_q     <= width_d;
      radius_q    <= radius_d;
      disc_q      <= disc_d;
      lag_q       <= lag_d;
      wp_q        <= wp_d;
      pend_q      <= pend_d;
      drain_q     <= drain_d;
      ocol_q      <= ocol_d;
      orow_q      <= orow_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
